// ----- hdl/pps_pkg.sv -----
// shared types, constants and the paeth predictor for the png paeth scanline filter
// no dependencies
`default_nettype none
package pps_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam int unsigned PIX_W = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned WIDTH_REG_W = 13;
	localparam int unsigned HEIGHT_REG_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [7:0] FILTER_TAG = 8'd4;

	typedef struct packed {
		logic       tag;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
		logic       image_end;
	} pps_res_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		da = $signed({3'b000, b}) - $signed({3'b000, c});
		db = $signed({3'b000, a}) - $signed({3'b000, c});
		dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
		pa = da[10] ? 10'(-da) : 10'(da);
		pb = db[10] ? 10'(-db) : 10'(db);
		pc = dc[10] ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
	endfunction

endpackage
`default_nettype wire

// ----- hdl/pps_line_mem.sv -----
// previous-row line store, one write and one registered read per cycle
// no package dependencies
`default_nettype none
module pps_line_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12,
	parameter int unsigned DW = 24
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/pps_serializer.sv -----
// output register stage: sends the tag on a row's first pixel, then three filtered bytes
// of the pixel, one per cycle unless byte_stall holds them; depends on pps_pkg
`default_nettype none
module pps_serializer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire pps_pkg::pps_res_t res,
	output logic                   free,
	output logic                   byte_valid,
	input  wire logic              byte_stall,
	output logic [7:0]             out_byte,
	output logic                   is_filter_tag,
	output logic                   row_end,
	output logic                   image_end
);
	import pps_pkg::*;

	localparam logic [1:0] SEL_TAG = 2'd0;
	localparam logic [1:0] SEL_RED = 2'd1;
	localparam logic [1:0] SEL_GREEN = 2'd2;
	localparam logic [1:0] SEL_BLUE = 2'd3;

	pps_res_t   res_q;
	logic [1:0] sel_q;
	logic       v_q;
	logic       take;

	assign take = v_q && !byte_stall;
	assign free = !v_q || (take && sel_q == SEL_BLUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
			sel_q <= SEL_TAG;
		end else if (load && free) begin
			v_q <= 1'b1;
			sel_q <= res.tag ? SEL_TAG : SEL_RED;
		end else if (take) begin
			if (sel_q == SEL_BLUE) begin
				v_q <= 1'b0;
			end
			sel_q <= sel_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	always_comb begin
		out_byte = FILTER_TAG;
		is_filter_tag = 1'b0;
		row_end = 1'b0;
		image_end = 1'b0;
		case (sel_q)
			SEL_TAG: begin
				out_byte = FILTER_TAG;
				is_filter_tag = 1'b1;
			end
			SEL_RED: out_byte = res_q.red;
			SEL_GREEN: out_byte = res_q.green;
			SEL_BLUE: begin
				out_byte = res_q.blue;
				row_end = res_q.row_end;
				image_end = res_q.image_end;
			end
			default: out_byte = FILTER_TAG;
		endcase
	end

	assign byte_valid = v_q;

endmodule
`default_nettype wire

// ----- hdl/png_paeth_scanline_filter.sv -----
// PNG Paeth scanline filter for RGB8 pixels. A pixel item is taken whenever the filter
// stage is free, which the byte-wide output register decides: it sends one byte per cycle
// unless byte_stall holds it, and sends the filter-type byte first on a row's first pixel.
// The previous row lives in a single-port-read line store with a registered read; a pixel
// that reads the entry its predecessor is writing in the same cycle gets that data forwarded.
// A pixel passes the filter stage register and the output register before its first byte.
// No clearing pass: the line store holds no reset.
// depends on pps_pkg, pps_line_mem, pps_serializer
`default_nettype none
module png_paeth_scanline_filter #(
	parameter int unsigned MAX_WIDTH = pps_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             pix_valid,
	output logic                                  pix_stall,
	input  wire logic [7:0]                       red_in,
	input  wire logic [7:0]                       green_in,
	input  wire logic [7:0]                       blue_in,
	output logic                                  byte_valid,
	input  wire logic                             byte_stall,
	output logic [7:0]                            out_byte,
	output logic                                  is_filter_tag,
	output logic                                  row_end,
	output logic                                  image_end
);
	import pps_pkg::*;

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CW-1:0]           col_q;
	logic [15:0]             row_q;
	logic [PIX_W-1:0]        left_q;
	logic [PIX_W-1:0]        upl_q;

	logic [16:0] w_eff;
	logic [16:0] h_eff;
	logic        last_col;
	logic        last_row;
	logic        pix_acc;
	logic [PIX_W-1:0] pix_in;

	logic             v_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    col_s1;
	logic             first_s1;
	logic             row0_s1;
	logic             lastc_s1;
	logic             lastr_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwdpix_s1;

	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] above;
	logic [PIX_W-1:0] left;
	logic [PIX_W-1:0] upl;
	logic             s1_adv;
	logic             ser_free;
	pps_res_t         res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_REG_W'(1);
			height_q <= HEIGHT_REG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = 17'(width_q);
		if (w_eff == 17'd0) begin
			w_eff = 17'd1;
		end else if (w_eff > MAX_W17) begin
			w_eff = MAX_W17;
		end
		h_eff = (height_q == '0) ? 17'd1 : 17'(height_q);
	end

	assign last_col = (17'(col_q) + 17'd1) >= w_eff;
	assign last_row = (17'(row_q) + 17'd1) >= h_eff;
	assign s1_adv = v_s1 && ser_free;
	assign pix_stall = v_s1 && !ser_free;
	assign pix_acc = pix_valid && !pix_stall;
	assign pix_in = {red_in, green_in, blue_in};

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1 <= pix_in;
			col_s1 <= col_q;
			first_s1 <= (col_q == '0);
			row0_s1 <= (row_q == '0);
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
			fwd_s1 <= s1_adv && (col_s1 == col_q);
			fwdpix_s1 <= pix_s1;
		end
	end

	pps_line_mem #(
		.DEPTH(MAX_WIDTH),
		.AW(CW),
		.DW(PIX_W)
	) u_line_mem (
		.clk(clk),
		.rd_en(pix_acc),
		.rd_addr(col_q),
		.rd_data(rd_data),
		.wr_en(s1_adv),
		.wr_addr(col_s1),
		.wr_data(pix_s1)
	);

	always_comb begin
		if (row0_s1) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwdpix_s1;
		end else begin
			above = rd_data;
		end
		left = first_s1 ? '0 : left_q;
		upl = first_s1 ? '0 : upl_q;
		res.tag = first_s1;
		res.red = pix_s1[23:16] - paeth(left[23:16], above[23:16], upl[23:16]);
		res.green = pix_s1[15:8] - paeth(left[15:8], above[15:8], upl[15:8]);
		res.blue = pix_s1[7:0] - paeth(left[7:0], above[7:0], upl[7:0]);
		res.row_end = lastc_s1;
		res.image_end = lastc_s1 && lastr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			upl_q <= '0;
		end else if (s1_adv) begin
			left_q <= pix_s1;
			upl_q <= above;
		end
	end

	pps_serializer u_serializer (
		.clk(clk),
		.arst_n(arst_n),
		.load(v_s1),
		.res(res),
		.free(ser_free),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.out_byte(out_byte),
		.is_filter_tag(is_filter_tag),
		.row_end(row_end),
		.image_end(image_end)
	);

	a_fwd_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && fwd_s1 |-> first_s1)
		else $error("forwarded line-store data on a pixel that is not a row start");

	a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && image_end |-> row_end && !is_filter_tag)
		else $error("image end flagged off a row end");

	a_tag_then_red: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && is_filter_tag |=> byte_valid && !is_filter_tag)
		else $error("filter tag not followed by a pixel byte");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |=> v_s1)
		else $error("accepted pixel lost before the filter stage");

endmodule
`default_nettype wire

// ----- tb/pps_filter_checker.sv -----
// checker for png_paeth_scanline_filter: follows register writes and pixel items, predicts
// the filtered byte stream and compares it with what the block sends
// depends on pps_pkg
module pps_filter_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           pix_valid,
	input  wire logic                           pix_stall,
	input  wire logic [7:0]                     red_in,
	input  wire logic [7:0]                     green_in,
	input  wire logic [7:0]                     blue_in,
	input  wire logic                           byte_valid,
	input  wire logic                           byte_stall,
	input  wire logic [7:0]                     out_byte,
	input  wire logic                           is_filter_tag,
	input  wire logic                           row_end,
	input  wire logic                           image_end,
	output int                                  errors,
	output int                                  pending,
	output int                                  row_now,
	output int                                  cols_filled
);
	import pps_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       tag;
		logic       last_in_row;
		logic       last_in_image;
	} filt_byte_t;

	filt_byte_t expected_bytes[$];
	logic [PIX_W-1:0] line_mem [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] left_px;
	logic [PIX_W-1:0] upleft_px;
	logic [WIDTH_REG_W-1:0] width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	int unsigned col_at;
	int unsigned row_at;
	int unsigned filled;
	int fails;

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		int ia;
		int ib;
		int ic;
		int p;
		int da;
		int db;
		int dc;
		ia = a;
		ib = b;
		ic = c;
		p = ia + ib - ic;
		da = (p > ia) ? p - ia : ia - p;
		db = (p > ib) ? p - ib : ib - p;
		dc = (p > ic) ? p - ic : ic - p;
		if (da <= db && da <= dc) begin
			return a;
		end else if (db <= dc) begin
			return b;
		end
		return c;
	endfunction

	task automatic filter_pixel(input logic [PIX_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int ch;
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] upleft;
		logic last_col;
		logic last_row;
		filt_byte_t fb;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		last_col = (col_at + 1 >= w);
		last_row = (row_at + 1 >= h);
		if (col_at == 0) begin
			left = '0;
			upleft = '0;
			fb = '{value: FILTER_TAG, tag: 1'b1, last_in_row: 1'b0, last_in_image: 1'b0};
			expected_bytes.push_back(fb);
		end else begin
			left = left_px;
			upleft = upleft_px;
		end
		above = (row_at == 0) ? '0 : line_mem[col_at];
		// red first, blue carries the row and image marks
		for (ch = 2; ch >= 0; ch--) begin
			fb.value = px[8*ch +: 8] - paeth_pick(left[8*ch +: 8], above[8*ch +: 8],
				upleft[8*ch +: 8]);
			fb.tag = 1'b0;
			fb.last_in_row = (ch == 0) && last_col;
			fb.last_in_image = (ch == 0) && last_col && last_row;
			expected_bytes.push_back(fb);
		end
		line_mem[col_at] = px;
		if (col_at >= filled) begin
			filled = col_at + 1;
		end
		if (last_col) begin
			col_at = 0;
			left_px = '0;
			upleft_px = '0;
			row_at = last_row ? 0 : ((row_at + 1) & 32'hFFFF);
		end else begin
			col_at = col_at + 1;
			left_px = px;
			upleft_px = above;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		filt_byte_t got;
		filt_byte_t want;
		if (!arst_n) begin
			width_reg = 1;
			height_reg = 1;
			left_px = '0;
			upleft_px = '0;
			col_at = 0;
			row_at = 0;
			filled = 0;
			fails = 0;
			expected_bytes.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: width_reg = cfg_data[WIDTH_REG_W-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall) begin
				filter_pixel({red_in, green_in, blue_in});
			end
			if (byte_valid && !byte_stall) begin
				got = {out_byte, is_filter_tag, row_end, image_end};
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected item: byte %h tag %b row_end %b image_end %b",
						$time, got.value, got.tag, got.last_in_row, got.last_in_image);
					fails++;
				end else begin
					want = expected_bytes.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected byte %h tag %b row_end %b image_end %b",
							$time, want.value, want.tag, want.last_in_row, want.last_in_image);
						$display("%0t:           actual byte %h tag %b row_end %b image_end %b",
							$time, got.value, got.tag, got.last_in_row, got.last_in_image);
						fails++;
					end
				end
			end
		end
		errors <= fails;
		pending <= expected_bytes.size();
		row_now <= row_at;
		cols_filled <= filled;
	end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for png_paeth_scanline_filter: clock, reset, register writes, pixel items,
// random stalls and the verdict; checking is done by pps_filter_checker
// depends on pps_pkg, png_paeth_scanline_filter and pps_filter_checker
module tb_top;
	import pps_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned MAX_BURST = 48;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	logic [7:0] red_in = '0;
	logic [7:0] green_in = '0;
	logic [7:0] blue_in = '0;
	logic byte_valid;
	logic byte_stall = 1'b0;
	logic [7:0] out_byte;
	logic is_filter_tag;
	logic row_end;
	logic image_end;
	int errors;
	int pending;
	int row_now;
	int cols_filled;
	int send_pct = 7;
	int stall_pct = 62;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned cur_span = 1;
	int unsigned cur_rows = 1;

	png_paeth_scanline_filter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.out_byte      (out_byte),
		.is_filter_tag (is_filter_tag),
		.row_end       (row_end),
		.image_end     (image_end)
	);

	pps_filter_checker u_filter_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.out_byte      (out_byte),
		.is_filter_tag (is_filter_tag),
		.row_end       (row_end),
		.image_end     (image_end),
		.errors        (errors),
		.pending       (pending),
		.row_now       (row_now),
		.cols_filled   (cols_filled)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		byte_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned span_of(input logic [CFG_DATA_W-1:0] data);
		logic [WIDTH_REG_W-1:0] w;
		w = data[WIDTH_REG_W-1:0];
		if (w == 0) begin
			return 1;
		end
		return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
	endfunction

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic drain();
		pix_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) begin
			cur_span = span_of(data);
		end else if (idx == REG_IMAGE_HEIGHT) begin
			cur_rows = (data == 0) ? 1 : data;
		end
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (pix_stall);
		items_sent++;
	endtask

	initial begin : stimulus
		int unsigned first;
		int unsigned n;
		int unsigned k;
		int unsigned wreq;
		int unsigned hreq;
		logic [1:0] sel;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// zero width and height act as one: every pixel is a whole image
		write_reg(REG_IMAGE_WIDTH, 16'd0);
		write_reg(REG_IMAGE_HEIGHT, 16'd0);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h80, 8'h01);

		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		send_pixel(8'hFF, 8'h00, 8'h80);
		send_pixel(8'h00, 8'hFF, 8'h01);
		send_pixel(8'h80, 8'h7F, 8'hFE);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'h7F);
		send_pixel(8'h01, 8'h80, 8'hFF);

		// unused index, then width with bits above the register set
		write_reg(REG_SPARE, 16'hFFFF);
		write_reg(REG_IMAGE_WIDTH, 16'hE002);
		for (k = 0; k < 4; k++) begin
			send_pixel(pick_sample(), pick_sample(), pick_sample());
		end

		write_reg(REG_IMAGE_WIDTH, 16'd4096);
		write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		for (k = 0; k < 5; k++) begin
			send_pixel(pick_sample(), pick_sample(), pick_sample());
		end
		// width above the store size saturates
		write_reg(REG_IMAGE_WIDTH, 16'h1FFF);
		for (k = 0; k < 3; k++) begin
			send_pixel(pick_sample(), pick_sample(), pick_sample());
		end
		// column already past the new width ends the row
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		send_pixel(8'h55, 8'hAA, 8'h0F);
		send_pixel(8'hF0, 8'h33, 8'hCC);
		send_pixel(8'h00, 8'hFF, 8'h80);
		// row already past the new height ends the image
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		send_pixel(8'hFF, 8'h01, 8'h00);

		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			if (items_sent - first >= 2 * RANDOM_ITEMS / 3) begin
				send_pct <= 0;
				stall_pct <= 0;
			end else if (items_sent - first >= RANDOM_ITEMS / 3) begin
				send_pct <= 62;
				stall_pct <= 7;
			end
			drain();
			sel = 2'($urandom_range(0, 3));
			if (sel[0]) begin
				case ($urandom_range(0, 9))
					0: wreq = 0;
					1: wreq = $urandom_range(9, 40);
					default: wreq = $urandom_range(1, 8);
				endcase
				// never let a later row read a column the line store has not seen
				if (row_now != 0 && span_of(16'(wreq)) > cols_filled) begin
					wreq = $urandom_range(1, cols_filled);
				end
				write_reg(REG_IMAGE_WIDTH, 16'(wreq));
			end
			if (sel[1]) begin
				case ($urandom_range(0, 9))
					0: hreq = 0;
					1: hreq = $urandom_range(7, 20);
					default: hreq = $urandom_range(1, 4);
				endcase
				write_reg(REG_IMAGE_HEIGHT, 16'(hreq));
			end
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 12);
			end else begin
				n = (cur_span * cur_rows > MAX_BURST) ? MAX_BURST : cur_span * cur_rows;
			end
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end
				send_pixel(pick_sample(), pick_sample(), pick_sample());
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/pps_pkg.sv
hdl/pps_line_mem.sv
hdl/pps_serializer.sv
hdl/png_paeth_scanline_filter.sv
tb/pps_filter_checker.sv
tb/tb_top.sv
